>>> hdl/sfr_pkg.sv
// Package with the shared types, codes and constants of the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int REPLACE_MAX_DEF = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_W           = 4;
	localparam logic [LEN_W-1:0] FIND_LEN_RST = 4'd1;

	typedef enum logic [1:0] {
		CFG_FIND_LEN      = 2'd0,
		CFG_FIND_BYTES    = 2'd1,
		CFG_REPLACE_LEN   = 2'd2,
		CFG_REPLACE_BYTES = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic pop;
	} sfr_cmd_t;

	typedef struct packed {
		logic none;
		logic final_out;
	} sfr_sts_t;

endpackage
`default_nettype wire

>>> hdl/sfr_ctrl.sv
// Controller state machine that sequences accept, evaluation and result transfers.
`default_nettype none
module sfr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire sfr_pkg::sfr_sts_t sts,
	output sfr_pkg::sfr_cmd_t     cmd
);
	import sfr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.none ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.pop = 1'b1;
					if (sts.final_out) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/sfr_datapath.sv
// Datapath with the configuration registers, the match window and the result buffer.
`default_nettype none
module sfr_datapath #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire sfr_pkg::cfg_index_t             cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire sfr_pkg::in_item_t               in_data,
	input  wire sfr_pkg::sfr_cmd_t               cmd,
	output sfr_pkg::sfr_sts_t                    sts,
	output sfr_pkg::out_item_t                   out_data
);
	import sfr_pkg::*;

	localparam int BUF_N   = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
	localparam int CNT_W   = $clog2(PATTERN_MAX + 1);
	localparam int RCNT_W  = $clog2(REPLACE_MAX + 1);
	localparam int BCNT_W  = $clog2(BUF_N + 1);

	logic [LEN_W-1:0]      find_len_q;
	logic [CFG_DATA_W-1:0] find_bytes_q;
	logic [LEN_W-1:0]      repl_len_q;
	logic [CFG_DATA_W-1:0] repl_bytes_q;

	logic [7:0]        win_q [PATTERN_MAX];
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;
	logic [7:0]        buf_q [BUF_N];
	logic [BCNT_W-1:0] rem_q;
	logic              marker_q;

	logic [LEN_W-1:0]  flen_raw;
	logic [LEN_W-1:0]  rlen_raw;
	logic [CNT_W-1:0]  flen;
	logic [RCNT_W-1:0] rlen;
	logic [CNT_W-1:0]  ins_idx;

	logic              full;
	logic              match;
	logic [7:0]        ev_buf [BUF_N];
	logic [BCNT_W-1:0] ev_n;
	logic [CNT_W-1:0]  ev_cnt;
	logic              ev_shift;
	logic              ev_marker;

	always_comb begin
		if (find_len_q == '0) begin
			flen_raw = LEN_W'(1);
		end else if (find_len_q > LEN_W'(PATTERN_MAX)) begin
			flen_raw = LEN_W'(PATTERN_MAX);
		end else begin
			flen_raw = find_len_q;
		end
		if (repl_len_q > LEN_W'(REPLACE_MAX)) begin
			rlen_raw = LEN_W'(REPLACE_MAX);
		end else begin
			rlen_raw = repl_len_q;
		end
		flen    = CNT_W'(flen_raw);
		rlen    = RCNT_W'(rlen_raw);
		ins_idx = (cnt_q >= flen) ? flen - CNT_W'(1) : cnt_q;
	end

	always_comb begin
		full  = (cnt_q == flen);
		match = full;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if ((CNT_W'(i) < flen) && (win_q[i] != find_bytes_q[8*i +: 8])) begin
				match = 1'b0;
			end
		end

		for (int i = 0; i < BUF_N; i++) begin
			ev_buf[i] = 8'h00;
		end
		ev_n      = '0;
		ev_cnt    = cnt_q;
		ev_shift  = 1'b0;
		ev_marker = 1'b0;

		if (match) begin
			for (int i = 0; i < REPLACE_MAX; i++) begin
				ev_buf[i] = repl_bytes_q[8*i +: 8];
			end
			ev_n   = BCNT_W'(rlen);
			ev_cnt = '0;
		end else if (full) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				ev_buf[i] = win_q[i];
			end
			ev_shift = 1'b1;
			ev_cnt   = flen - CNT_W'(1);
			ev_n     = last_q ? BCNT_W'(flen) : BCNT_W'(1);
		end else if (last_q) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				ev_buf[i] = win_q[i];
			end
			ev_n = BCNT_W'(cnt_q);
		end

		if (last_q) begin
			ev_cnt = '0;
			if (ev_n == '0) begin
				ev_n      = BCNT_W'(1);
				ev_marker = 1'b1;
				ev_buf[0] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_len_q   <= FIND_LEN_RST;
			find_bytes_q <= '0;
			repl_len_q   <= '0;
			repl_bytes_q <= '0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			rem_q        <= '0;
			marker_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_FIND_LEN: begin
						find_len_q <= cfg_data[LEN_W-1:0];
						cnt_q      <= '0;
					end
					CFG_FIND_BYTES: begin
						find_bytes_q <= cfg_data;
					end
					CFG_REPLACE_LEN: begin
						repl_len_q <= cfg_data[LEN_W-1:0];
					end
					CFG_REPLACE_BYTES: begin
						repl_bytes_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				cnt_q  <= ins_idx + CNT_W'(1);
				last_q <= in_data.in_last;
			end
			if (cmd.eval) begin
				cnt_q    <= ev_cnt;
				rem_q    <= ev_n;
				marker_q <= ev_marker;
			end
			if (cmd.pop) begin
				rem_q <= rem_q - BCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (CNT_W'(i) == ins_idx) begin
					win_q[i] <= in_data.in_byte;
				end
			end
		end
		if (cmd.eval) begin
			for (int i = 0; i < BUF_N; i++) begin
				buf_q[i] <= ev_buf[i];
			end
			if (ev_shift) begin
				for (int i = 0; i < PATTERN_MAX - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
			end
		end
		if (cmd.pop) begin
			for (int i = 0; i < BUF_N - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign sts.none      = (ev_n == '0);
	assign sts.final_out = (rem_q == BCNT_W'(1));

	assign out_data.out_byte   = marker_q ? 8'h00 : buf_q[0];
	assign out_data.byte_valid = ~marker_q;
	assign out_data.out_last   = last_q & (rem_q == BCNT_W'(1));

endmodule
`default_nettype wire

>>> hdl/stream_find_replace_top.sv
// Top level of the stream find-and-replace block.
// Rewrites a byte stream, replacing every non-overlapping occurrence of the configured
// pattern (1 to PATTERN_MAX bytes) with the configured replacement (0 to REPLACE_MAX
// bytes). One input byte is taken at a time: each input transfer is captured into the
// window, then compared and loaded into the result buffer, then each result is passed
// on as out_ready allows. An item yields n results, n being 0 or 1 in steady state
// and up to the larger of PATTERN_MAX and REPLACE_MAX after a match or at end of
// string. Configuration must be written only while no item is in flight; the block
// does not enforce it. Writing the pattern length discards the bytes held in the window.
`default_nettype none
module stream_find_replace_top #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire sfr_pkg::cfg_index_t            cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire sfr_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output sfr_pkg::out_item_t                  out_data
);
	import sfr_pkg::*;

	sfr_cmd_t cmd;
	sfr_sts_t sts;

	assign cfg_ready = 1'b1;

	sfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sfr_datapath #(
		.PATTERN_MAX (PATTERN_MAX),
		.REPLACE_MAX (REPLACE_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stream find-and-replace block, with a predictor, driver and monitor.
module testbench;
	import sfr_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_FIND_LEN;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	stream_find_replace_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	logic [LEN_W-1:0]      find_len_q = FIND_LEN_RST;
	logic [CFG_DATA_W-1:0] find_pat   = '0;
	logic [LEN_W-1:0]      repl_len_q = '0;
	logic [CFG_DATA_W-1:0] repl_pat   = '0;
	logic [7:0]            win_buf [PATTERN_MAX_DEF];
	int unsigned           win_fill   = 0;

	in_item_t  src_bytes [$];
	out_item_t rewritten [$];
	out_item_t want;
	bit        calm  = 1'b0;
	bit        alpha = 1'b0;
	int        errors = 0;
	int        n_in = 0;
	int        n_out = 0;
	int        n_markers = 0;
	int        n_cfg = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pattern_len();
		int unsigned n;
		n = find_len_q;
		if (n == 0)
			n = 1;
		if (n > PATTERN_MAX_DEF)
			n = PATTERN_MAX_DEF;
		return n;
	endfunction

	function automatic void rewrite_byte(in_item_t it);
		int unsigned flen;
		int unsigned rlen;
		int unsigned k;
		bit          hit;
		out_item_t   res [$];
		flen = pattern_len();
		rlen = (repl_len_q > REPLACE_MAX_DEF) ? REPLACE_MAX_DEF : repl_len_q;
		if (win_fill >= flen)
			win_fill = flen - 1;
		win_buf[win_fill] = it.in_byte;
		win_fill++;
		if (win_fill == flen) begin
			hit = 1'b1;
			for (k = 0; k < flen; k++)
				if (win_buf[k] != find_pat[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				for (k = 0; k < rlen; k++)
					res.push_back('{repl_pat[8*k +: 8], 1'b1, 1'b0});
				win_fill = 0;
			end else begin
				res.push_back('{win_buf[0], 1'b1, 1'b0});
				for (k = 1; k < flen; k++)
					win_buf[k-1] = win_buf[k];
				win_fill--;
			end
		end
		if (it.in_last) begin
			for (k = 0; k < win_fill; k++)
				res.push_back('{win_buf[k], 1'b1, 1'b0});
			win_fill = 0;
			if (res.size() == 0) begin
				res.push_back('{8'h00, 1'b0, 1'b1});
			end else begin
				res[res.size()-1].out_last = 1'b1;
			end
		end
		foreach (res[i])
			rewritten.push_back(res[i]);
	endfunction

	// Driver: presents queued bytes, idling at random unless the calm stretch is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				rewrite_byte(in_data);
				n_in++;
			end
			if (!in_valid || in_ready) begin
				if (src_bytes.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
					in_valid <= 1'b1;
					in_data  <= src_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_out++;
				if (!out_data.byte_valid)
					n_markers++;
				if (rewritten.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual byte=%02h valid=%0b last=%0b",
						$time, out_data.out_byte, out_data.byte_valid, out_data.out_last);
				end else begin
					want = rewritten.pop_front();
					if (out_data.out_byte !== want.out_byte) begin
						errors++;
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, want.out_byte, out_data.out_byte);
					end
					if (out_data.byte_valid !== want.byte_valid) begin
						errors++;
						$display("%0t: byte_valid mismatch, expected %0b, actual %0b",
							$time, want.byte_valid, out_data.byte_valid);
					end
					if (out_data.out_last !== want.out_last) begin
						errors++;
						$display("%0t: out_last mismatch, expected %0b, actual %0b",
							$time, want.out_last, out_data.out_last);
					end
				end
			end
			out_ready <= calm || $urandom_range(99) >= 22;
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			CFG_FIND_LEN: begin
				find_len_q = val[LEN_W-1:0];
				win_fill   = 0;
			end
			CFG_FIND_BYTES:    find_pat   = val;
			CFG_REPLACE_LEN:   repl_len_q = val[LEN_W-1:0];
			CFG_REPLACE_BYTES: repl_pat   = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [LEN_W-1:0] flen, logic [CFG_DATA_W-1:0] fpat,
			logic [LEN_W-1:0] rlen, logic [CFG_DATA_W-1:0] rpat);
		write_reg(CFG_FIND_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, flen});
		write_reg(CFG_FIND_BYTES, fpat);
		write_reg(CFG_REPLACE_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, rlen});
		write_reg(CFG_REPLACE_BYTES, rpat);
	endtask

	// The sender holds off here until every predicted result has arrived.
	task automatic drain();
		do
			@(negedge clk);
		while (src_bytes.size() != 0 || in_valid || rewritten.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic send(logic [7:0] b, logic last);
		src_bytes.push_back('{b, last});
	endtask

	function automatic logic [7:0] noise_byte();
		if (alpha && $urandom_range(2) != 0)
			return 8'h61 + 8'($urandom_range(1));
		return 8'($urandom);
	endfunction

	task automatic queue_strings(int unsigned budget, bit cut_short);
		int unsigned flen;
		int unsigned pushed;
		int unsigned m;
		int unsigned r;
		logic [7:0]  str [$];
		flen   = pattern_len();
		pushed = 0;
		while (pushed < budget) begin
			str.delete();
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(9);
				if (r < 5) begin
					for (int j = 0; j < flen; j++)
						str.push_back(find_pat[8*j +: 8]);
				end else if (r < 7) begin
					m = $urandom_range(1, flen);
					for (int j = 0; j < m; j++)
						str.push_back(find_pat[8*j +: 8]);
				end else begin
					str.push_back(noise_byte());
				end
			end
			foreach (str[i])
				send(str[i], i == str.size() - 1);
			pushed += str.size();
		end
		if (cut_short) begin
			m = $urandom_range(1, 7);
			for (int j = 0; j < m; j++)
				send((j < flen) ? find_pat[8*j +: 8] : noise_byte(), 1'b0);
		end
	endtask

	initial begin
		logic [LEN_W-1:0]      flen;
		logic [LEN_W-1:0]      rlen;
		logic [CFG_DATA_W-1:0] fpat;
		foreach (win_buf[i])
			win_buf[i] = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-byte pattern of zero, deleted on match, so the final
		// zero leaves a bare end marker.
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		send(8'h41, 1'b1);
		drain();

		// Three-byte pattern with an oversized replacement length; partial match flushed.
		set_config(4'd3, 64'h636261, 4'd15, 64'h8877665544332211);
		send(8'h78, 1'b0);
		send(8'h61, 1'b0);
		send(8'h62, 1'b0);
		send(8'h63, 1'b0);
		send(8'h61, 1'b0);
		send(8'h62, 1'b0);
		send(8'h63, 1'b0);
		send(8'h79, 1'b1);
		send(8'h61, 1'b0);
		send(8'h62, 1'b1);
		drain();

		// A zero pattern length behaves as one.
		set_config(4'd0, 64'h61, 4'd2, 64'h595A);
		send(8'h61, 1'b0);
		send(8'h61, 1'b1);
		drain();

		// An oversized pattern length behaves as the maximum; the string is left open so
		// the next length write discards the window.
		set_config(4'd15, '1, 4'd8, 64'h0);
		repeat (7) send(8'hFF, 1'b0);
		send(8'hFF, 1'b1);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin flen = 4'd1;  rlen = 4'd0;  end
				1: begin flen = 4'd8;  rlen = 4'd8;  end
				2: begin flen = 4'd0;  rlen = 4'd1;  end
				3: begin flen = 4'd15; rlen = 4'd15; end
				default: begin
					flen = 4'($urandom_range(1, PATTERN_MAX_DEF));
					rlen = 4'($urandom_range(0, REPLACE_MAX_DEF));
				end
			endcase
			alpha = (phase % 2 == 1) || ($urandom_range(3) == 0);
			for (int k = 0; k < 8; k++)
				fpat[8*k +: 8] = alpha ? 8'h61 + 8'($urandom_range(1)) : 8'($urandom);
			set_config(flen, fpat, rlen, {$urandom, $urandom});
			calm = (phase == 4);
			queue_strings(42, $urandom_range(3) == 0);
			drain();
			calm = 1'b0;
		end

		$display("Covered %0d byte transfers and %0d result transfers, %0d of them bare end markers,",
			n_in, n_out, n_markers);
		$display("across %0d register writes including out-of-range lengths and mid-string rewrites.",
			n_cfg);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
